// ===== hw/rtl/decision_tree_inference_unit_macros.svh =====
`ifndef DECISION_TREE_INFERENCE_UNIT_MACROS_SVH
`define DECISION_TREE_INFERENCE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DTI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define DTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dti_pkg.sv =====
`timescale 1ns / 1ps
package dti_pkg;

	localparam int NODE_COUNT_DEF    = 256;
	localparam int FEATURE_COUNT_DEF = 256;
	localparam int MAX_DEPTH_DEF     = 16;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 8;
	localparam int DATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_NODE    = 2'd0,
		CMD_WRITE_FEATURE = 2'd1,
		CMD_CLASSIFY      = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NODE_RD,
		ST_NODE_CHK,
		ST_FEAT_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0]         child;
		logic [IDX_W-1:0]         feature;
		logic signed [DATA_W-1:0] threshold;
		logic                     label;
	} node_t;

	typedef struct packed {
		logic clr_wr;
		logic wr_en;
		logic walk_start;
		logic step;
		logic set_ok;
		logic set_err;
		logic load_out;
	} dti_ctl_t;

	typedef struct packed {
		logic clear_last;
		logic child_zero;
		logic depth_hit;
		logic next_oor;
	} dti_status_t;

endpackage

// ===== hw/rtl/decision_tree_inference_unit.sv =====
// decision tree inference unit
// input channel (in_valid/in_ready) takes one command word: write node, write
// feature or classify; command 3 is taken and dropped. writes take effect in
// the cycle the word is accepted and give no result word.
// a classify walks the node table from node 0; each level passes through node
// table read, feature table read, then compare and step. the input takes the
// next word once the result is in the output register.
// output channel (out_valid/out_ready) carries label and walk_error from an
// output register; a stalled receiver holds the word, and a further classify
// finishing meanwhile waits in its last state until the register frees.
// after reset the node table is swept clear, with in_ready low, so every node
// starts as a leaf with all fields zero; feature data is undefined until written.
`timescale 1ns / 1ps
module decision_tree_inference_unit import dti_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
	parameter int MAX_DEPTH     = MAX_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [IDX_W-1:0]         node_index,
	input  logic [IDX_W-1:0]         child_index,
	input  logic [IDX_W-1:0]         feature_index,
	input  logic signed [DATA_W-1:0] threshold,
	input  logic                     leaf_label,
	input  logic signed [DATA_W-1:0] feature_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     label,
	output logic                     walk_error
);

	dti_ctl_t    ctl;
	dti_status_t status;

	dti_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.ctl       (ctl)
	);

	dti_datapath #(
		.NODE_COUNT    (NODE_COUNT),
		.FEATURE_COUNT (FEATURE_COUNT),
		.MAX_DEPTH     (MAX_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.status        (status),
		.command       (command),
		.node_index    (node_index),
		.child_index   (child_index),
		.feature_index (feature_index),
		.threshold     (threshold),
		.leaf_label    (leaf_label),
		.feature_value (feature_value),
		.label         (label),
		.walk_error    (walk_error)
	);

endmodule

// ===== hw/rtl/dti_datapath.sv =====
`timescale 1ns / 1ps
module dti_datapath import dti_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
	parameter int MAX_DEPTH     = MAX_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dti_ctl_t                 ctl,
	output dti_status_t              status,
	input  logic [CMD_W-1:0]         command,
	input  logic [IDX_W-1:0]         node_index,
	input  logic [IDX_W-1:0]         child_index,
	input  logic [IDX_W-1:0]         feature_index,
	input  logic signed [DATA_W-1:0] threshold,
	input  logic                     leaf_label,
	input  logic signed [DATA_W-1:0] feature_value,
	output logic                     label,
	output logic                     walk_error
);

	localparam int NIW = $clog2(NODE_COUNT);
	localparam int FIW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int DW  = $clog2(MAX_DEPTH + 1);

	node_t                     node_mem [NODE_COUNT];
	logic signed [DATA_W-1:0]  feat_mem [FEATURE_COUNT];

	logic [NIW-1:0]            clr_q;
	logic [NIW-1:0]            k_q;
	logic [DW-1:0]             steps_q;
	node_t                     node_q;
	logic signed [DATA_W-1:0]  feat_q;
	logic                      feat_ok_q;
	logic                      res_label_q;
	logic                      res_err_q;
	logic                      label_q;
	logic                      walk_error_q;

	logic                      node_we;
	logic                      feat_we;
	node_t                     node_wdata;
	logic signed [DATA_W-1:0]  feat_val;
	logic                      go_left;
	logic [IDX_W:0]            next_idx;

	always_comb begin
		node_we = 1'b0;
		feat_we = 1'b0;
		if (ctl.wr_en) begin
			case (command)
				CMD_WRITE_NODE:    node_we = 32'(node_index) < NODE_COUNT;
				CMD_WRITE_FEATURE: feat_we = 32'(feature_index) < FEATURE_COUNT;
				default:           ;
			endcase
		end
	end

	assign node_wdata = '{child: child_index, feature: feature_index,
		threshold: threshold, label: leaf_label};

	// out-of-range feature slot reads as zero
	assign feat_val = feat_ok_q ? feat_q : '0;
	assign go_left  = feat_val < node_q.threshold;
	assign next_idx = {1'b0, node_q.child} + {{IDX_W{1'b0}}, ~go_left};

	assign status.clear_last = clr_q == NIW'(NODE_COUNT - 1);
	assign status.child_zero = node_q.child == '0;
	assign status.depth_hit  = steps_q >= DW'(MAX_DEPTH);
	assign status.next_oor   = 32'(next_idx) >= NODE_COUNT;

	always_ff @(posedge clk) begin
		if (ctl.clr_wr) begin
			node_mem[clr_q] <= '0;
		end else if (node_we) begin
			node_mem[NIW'(node_index)] <= node_wdata;
		end
		node_q <= node_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (feat_we) begin
			feat_mem[FIW'(feature_index)] <= feature_value;
		end
		feat_q    <= feat_mem[FIW'(node_q.feature)];
		feat_ok_q <= 32'(node_q.feature) < FEATURE_COUNT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.walk_start) begin
			k_q     <= '0;
			steps_q <= '0;
		end else if (ctl.step) begin
			k_q     <= NIW'(next_idx);
			steps_q <= steps_q + 1'b1;
		end
		if (ctl.set_ok) begin
			res_label_q <= node_q.label;
			res_err_q   <= 1'b0;
		end else if (ctl.set_err) begin
			res_label_q <= 1'b0;
			res_err_q   <= 1'b1;
		end
		if (ctl.load_out) begin
			label_q      <= res_label_q;
			walk_error_q <= res_err_q;
		end
	end

	assign label      = label_q;
	assign walk_error = walk_error_q;

endmodule

// ===== hw/rtl/dti_controller.sv =====
`timescale 1ns / 1ps
module dti_controller import dti_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] command,
	output logic             out_valid,
	input  logic             out_ready,
	input  dti_status_t      status,
	output dti_ctl_t         ctl
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   is_classify;

	assign out_free    = !out_valid_q || out_ready;
	assign is_classify = command == CMD_CLASSIFY;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && is_classify) state_d = ST_NODE_RD;
			end
			ST_NODE_RD: state_d = ST_NODE_CHK;
			ST_NODE_CHK: begin
				if (status.child_zero || status.depth_hit) state_d = ST_DONE;
				else state_d = ST_FEAT_CMP;
			end
			ST_FEAT_CMP: begin
				if (status.next_oor) state_d = ST_DONE;
				else state_d = ST_NODE_RD;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: ctl.clr_wr = 1'b1;
			ST_IDLE: begin
				in_ready       = 1'b1;
				ctl.wr_en      = in_valid;
				ctl.walk_start = in_valid && is_classify;
			end
			ST_NODE_CHK: begin
				ctl.set_ok  = status.child_zero;
				ctl.set_err = !status.child_zero && status.depth_hit;
			end
			ST_FEAT_CMP: begin
				ctl.set_err = status.next_oor;
				ctl.step    = !status.next_oor;
			end
			ST_DONE: ctl.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/dti_checker.sv =====
`timescale 1ns / 1ps
`include "decision_tree_inference_unit_macros.svh"
module dti_checker import dti_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [CMD_W-1:0] command,
	input logic             out_valid,
	input logic             out_ready,
	input logic             label,
	input logic             walk_error
);

	`DTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(label) && $stable(walk_error), "result word changed while stalled")

	`DTI_ASSERT_NOW(a_err_label, out_valid && walk_error, !label, "failed walk must report label 0")

	`DTI_ASSERT_NEXT(a_busy_after_classify, in_valid && in_ready && command == CMD_CLASSIFY, !in_ready, "input taken during a walk")

	`DTI_ASSERT_NEXT(a_write_no_result, in_valid && in_ready && command != CMD_CLASSIFY && !out_valid, !out_valid, "result word without a classify")

endmodule

bind decision_tree_inference_unit dti_checker u_dti_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.command    (command),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.label      (label),
	.walk_error (walk_error)
);
